/* rtl/stereo_volume_saturating_mixer_macros.svh */
// Assertion macros shared by the stereo volume mixer RTL.
// Included by the controller and datapath; needs no other file.
// Define SYNTH to compile the checks out.
`ifndef STEREO_VOLUME_SATURATING_MIXER_MACROS_SVH
`define STEREO_VOLUME_SATURATING_MIXER_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication: cons must hold whenever ante holds.
`define SVSM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("svsm assertion failed");
// Next-cycle implication: cons must hold in the cycle after ante.
`define SVSM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("svsm assertion failed");
`else
`define SVSM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SVSM_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/svsm_pkg.sv */
// Package of the stereo volume mixer: widths, constants, command/status types
// and the arithmetic helpers. Depends on nothing.
`timescale 1ns / 1ps

package svsm_pkg;

    localparam int CHANNELS         = 4;
    localparam int VOLUME_FRAC_BITS = 8;

    localparam int SAMPLE_W   = 16;
    localparam int CH_W       = 2;
    localparam int NUM_REGS   = 8;
    localparam int REG_CH     = NUM_REGS / 2;
    localparam int REG_SEL_W  = $clog2(REG_CH);
    localparam int DIV_W      = 31;
    localparam int CFG_IDX_W  = 4;

    // Numerator magnitude, signed scaled value, widened sum
    localparam int NUM_W = SAMPLE_W + VOLUME_FRAC_BITS;
    localparam int SCL_W = NUM_W + 1;
    localparam int SUM_W = NUM_W + 2;
    localparam int CNT_W = $clog2(NUM_W);

    localparam logic [CNT_W-1:0]     CNT_LAST  = CNT_W'(NUM_W - 1);
    localparam logic [CH_W:0]        CH_LIMIT  = (CH_W + 1)'(CHANNELS);
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT = CFG_IDX_W'(NUM_REGS);
    localparam logic [DIV_W-1:0]     DIV_RESET = DIV_W'(256);
    localparam logic [DIV_W-1:0]     DIV_ONE   = DIV_W'(1);

    // Low bit of a register index selects the side
    localparam logic SIDE_LEFT  = 1'b0;
    localparam logic SIDE_RIGHT = 1'b1;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    typedef struct packed {
        logic load;      // capture word, clear accumulators on first
        logic div_step;  // one restoring divide step in both lanes
        logic add_l;     // accumulate left side
        logic add_r;     // accumulate right side
        logic emit;      // load output register
    } ctrl_cmd_t;

    typedef struct packed {
        logic last;      // word in flight closes a frame
        logic out_busy;  // output register cannot take a result
    } dp_sts_t;

    // Magnitude of sample << VOLUME_FRAC_BITS
    function automatic logic [NUM_W-1:0] num_mag(input logic signed [SAMPLE_W-1:0] smp);
        logic [NUM_W-1:0] num;
        num = {smp, {VOLUME_FRAC_BITS{1'b0}}};
        return smp[SAMPLE_W-1] ? (~num + NUM_W'(1)) : num;
    endfunction

    // Scaled side: quotient with sign restored, or the sample unscaled
    function automatic logic signed [SCL_W-1:0] side_value(
        input logic signed [SAMPLE_W-1:0] smp,
        input logic [DIV_W-1:0]           dvs,
        input logic [NUM_W-1:0]           quo
    );
        logic signed [SCL_W-1:0] q;
        q = signed'({1'b0, quo});
        if (smp == '0 || dvs <= DIV_ONE)
            return SCL_W'(smp);
        return smp[SAMPLE_W-1] ? -q : q;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat_add(
        input logic signed [SAMPLE_W-1:0] acc,
        input logic signed [SCL_W-1:0]    v
    );
        logic signed [SUM_W-1:0] s;
        s = SUM_W'(acc) + SUM_W'(v);
        if (s > SUM_W'(SAMPLE_MAX))
            return SAMPLE_MAX;
        if (s < SUM_W'(SAMPLE_MIN))
            return SAMPLE_MIN;
        return s[SAMPLE_W-1:0];
    endfunction

endpackage

/* rtl/svsm_smp_if.sv */
// Sample input channel of the stereo volume mixer.
// Depends on svsm_pkg.
`timescale 1ns / 1ps

interface svsm_smp_if;
    logic                                valid;
    logic                                ready;
    logic [svsm_pkg::CH_W-1:0]           channel;
    logic signed [svsm_pkg::SAMPLE_W-1:0] sample_in;
    logic                                first_of_frame;
    logic                                last_of_frame;
    logic                                mono_out;

    modport source (output valid, channel, sample_in, first_of_frame, last_of_frame,
                    mono_out, input ready);
    modport sink   (input valid, channel, sample_in, first_of_frame, last_of_frame,
                    mono_out, output ready);
endinterface

/* rtl/svsm_mix_if.sv */
// Mixed output channel of the stereo volume mixer.
// Depends on svsm_pkg.
`timescale 1ns / 1ps

interface svsm_mix_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [svsm_pkg::SAMPLE_W-1:0] mix_left;
    logic signed [svsm_pkg::SAMPLE_W-1:0] mix_right;

    modport source (output valid, mix_left, mix_right, input ready);
    modport sink   (input valid, mix_left, mix_right, output ready);
endinterface

/* rtl/svsm_cfg_if.sv */
// Configuration write channel of the stereo volume mixer.
// Depends on svsm_pkg.
`timescale 1ns / 1ps

interface svsm_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [svsm_pkg::CFG_IDX_W-1:0]     index;
    logic [svsm_pkg::DIV_W-1:0]         data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/svsm_div_lane.sv */
// One restoring divider lane: unsigned numerator magnitude by a 31-bit divisor,
// one quotient bit per step. Depends on svsm_pkg.
`timescale 1ns / 1ps

module svsm_div_lane (
    input  logic                           clk,
    input  logic                           load,
    input  logic                           step,
    input  logic [svsm_pkg::NUM_W-1:0]     num,
    input  logic [svsm_pkg::DIV_W-1:0]     divisor,
    output logic [svsm_pkg::NUM_W-1:0]     quo
);
    logic [svsm_pkg::DIV_W-1:0] rem_reg, rem_next;
    logic [svsm_pkg::NUM_W-1:0] quo_reg, quo_next;
    logic [svsm_pkg::DIV_W:0]   part;
    logic [svsm_pkg::DIV_W:0]   trial;
    logic                       fits;

    always_comb
    begin
        part  = {rem_reg, quo_reg[svsm_pkg::NUM_W-1]};
        trial = part - {1'b0, divisor};
        // No borrow: the shifted remainder holds the divisor
        fits  = ~trial[svsm_pkg::DIV_W];
        rem_next = rem_reg;
        quo_next = quo_reg;
        if (load)
        begin
            rem_next = '0;
            quo_next = num;
        end
        else if (step)
        begin
            rem_next = fits ? trial[svsm_pkg::DIV_W-1:0] : part[svsm_pkg::DIV_W-1:0];
            quo_next = {quo_reg[svsm_pkg::NUM_W-2:0], fits};
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign quo = quo_reg;
endmodule

/* rtl/svsm_ctrl.sv */
// Controller of the stereo volume mixer: sequences capture, divide, the two
// accumulate steps and, for a word that closes a frame, the emit. Depends on svsm_pkg and the macro header.
`timescale 1ns / 1ps
`include "stereo_volume_saturating_mixer_macros.svh"

module svsm_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  svsm_pkg::dp_sts_t    sts,
    output svsm_pkg::ctrl_cmd_t  cmd
);
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_DIV   = 5'b00010,
        S_ADD_L = 5'b00100,
        S_ADD_R = 5'b01000,
        S_EMIT  = 5'b10000
    } state_t;

    state_t                     state_reg, state_next;
    logic [svsm_pkg::CNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + svsm_pkg::CNT_W'(1);
                if (cnt_reg == svsm_pkg::CNT_LAST)
                    state_next = S_ADD_L;
            end
            S_ADD_L:
            begin
                cmd.add_l  = 1'b1;
                state_next = S_ADD_R;
            end
            S_ADD_R:
            begin
                cmd.add_r  = 1'b1;
                state_next = sts.last ? S_EMIT : S_IDLE;
            end
            S_EMIT:
            begin
                // hold until the output register frees up
                if (!sts.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    `SVSM_ASSERT_IMP(a_emit_room, clk, rst_n, cmd.emit, !sts.out_busy)
    `SVSM_ASSERT_NXT(a_load_starts_div, clk, rst_n, cmd.load, state_reg == S_DIV && cnt_reg == '0)
    `SVSM_ASSERT_IMP(a_div_full_length, clk, rst_n, state_reg == S_ADD_L, $past(cnt_reg) == svsm_pkg::CNT_LAST)
endmodule

/* rtl/svsm_dp.sv */
// Datapath of the stereo volume mixer: divisor registers, item registers, two
// divider lanes, saturating accumulators and the output register.
// Depends on svsm_pkg, svsm_div_lane and the macro header.
`timescale 1ns / 1ps
`include "stereo_volume_saturating_mixer_macros.svh"

module svsm_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  svsm_pkg::ctrl_cmd_t                  cmd,
    output svsm_pkg::dp_sts_t                    sts,
    input  logic [svsm_pkg::CH_W-1:0]            channel,
    input  logic signed [svsm_pkg::SAMPLE_W-1:0] sample_in,
    input  logic                                 first_of_frame,
    input  logic                                 last_of_frame,
    input  logic                                 mono_out,
    input  logic                                 cfg_valid,
    input  logic [svsm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [svsm_pkg::DIV_W-1:0]           cfg_data,
    input  logic                                 out_ready,
    output logic                                 out_valid,
    output logic signed [svsm_pkg::SAMPLE_W-1:0] mix_left,
    output logic signed [svsm_pkg::SAMPLE_W-1:0] mix_right
);
    logic [svsm_pkg::DIV_W-1:0] ldiv_reg [svsm_pkg::REG_CH];
    logic [svsm_pkg::DIV_W-1:0] rdiv_reg [svsm_pkg::REG_CH];

    logic [svsm_pkg::CH_W-1:0]            ch_reg;
    logic signed [svsm_pkg::SAMPLE_W-1:0] smp_reg;
    logic                                 last_reg;
    logic                                 mono_reg;

    logic signed [svsm_pkg::SAMPLE_W-1:0] acc_left_reg, acc_left_next;
    logic signed [svsm_pkg::SAMPLE_W-1:0] acc_right_reg, acc_right_next;

    logic                                 out_valid_reg, out_valid_next;
    logic signed [svsm_pkg::SAMPLE_W-1:0] mix_left_reg;
    logic signed [svsm_pkg::SAMPLE_W-1:0] mix_right_reg;

    logic [svsm_pkg::DIV_W-1:0]           ldiv;
    logic [svsm_pkg::DIV_W-1:0]           rdiv;
    logic [svsm_pkg::NUM_W-1:0]           num_in;
    logic [svsm_pkg::NUM_W-1:0]           lquo;
    logic [svsm_pkg::NUM_W-1:0]           rquo;
    logic signed [svsm_pkg::SCL_W-1:0]    lscl;
    logic signed [svsm_pkg::SCL_W-1:0]    rscl;
    logic                                 present;
    logic [svsm_pkg::REG_SEL_W-1:0]       cfg_sel;

    assign ldiv    = ldiv_reg[ch_reg];
    assign rdiv    = rdiv_reg[ch_reg];
    assign num_in  = svsm_pkg::num_mag(sample_in);
    assign present = {1'b0, ch_reg} < svsm_pkg::CH_LIMIT;
    assign cfg_sel = cfg_index[svsm_pkg::REG_SEL_W:1];

    svsm_div_lane u_div_left (
        .clk     (clk),
        .load    (cmd.load),
        .step    (cmd.div_step),
        .num     (num_in),
        .divisor (ldiv),
        .quo     (lquo)
    );

    svsm_div_lane u_div_right (
        .clk     (clk),
        .load    (cmd.load),
        .step    (cmd.div_step),
        .num     (num_in),
        .divisor (rdiv),
        .quo     (rquo)
    );

    assign lscl = svsm_pkg::side_value(smp_reg, ldiv, lquo);
    assign rscl = svsm_pkg::side_value(smp_reg, rdiv, rquo);

    always_comb
    begin
        acc_left_next  = acc_left_reg;
        acc_right_next = acc_right_reg;
        if (cmd.load && first_of_frame)
        begin
            acc_left_next  = '0;
            acc_right_next = '0;
        end
        else if (cmd.add_l && present)
        begin
            acc_left_next = svsm_pkg::sat_add(acc_left_reg, lscl);
        end
        else if (cmd.add_r && present)
        begin
            if (mono_reg)
                acc_left_next = svsm_pkg::sat_add(acc_left_reg, rscl);
            else
                acc_right_next = svsm_pkg::sat_add(acc_right_reg, rscl);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < svsm_pkg::REG_CH; i++)
            begin
                ldiv_reg[i] <= svsm_pkg::DIV_RESET;
                rdiv_reg[i] <= svsm_pkg::DIV_RESET;
            end
            acc_left_reg  <= '0;
            acc_right_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_index < svsm_pkg::REG_LIMIT)
            begin
                if (cfg_index[0] == svsm_pkg::SIDE_LEFT)
                    ldiv_reg[cfg_sel] <= cfg_data;
                else
                    rdiv_reg[cfg_sel] <= cfg_data;
            end
            acc_left_reg  <= acc_left_next;
            acc_right_reg <= acc_right_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ch_reg   <= channel;
            smp_reg  <= sample_in;
            last_reg <= last_of_frame;
            mono_reg <= mono_out;
        end
        if (cmd.emit)
        begin
            mix_left_reg  <= acc_left_reg;
            mix_right_reg <= acc_right_reg;
        end
    end

    assign sts.last     = last_reg;
    assign sts.out_busy = out_valid_reg & ~out_ready;
    assign out_valid    = out_valid_reg;
    assign mix_left     = mix_left_reg;
    assign mix_right    = mix_right_reg;

    `SVSM_ASSERT_NXT(a_mono_keeps_right, clk, rst_n, cmd.add_r && mono_reg, $stable(acc_right_reg))
    `SVSM_ASSERT_NXT(a_emit_loads_out, clk, rst_n, cmd.emit, out_valid_reg && mix_left_reg == $past(acc_left_reg))
endmodule

/* rtl/stereo_volume_saturating_mixer.sv */
// Stereo volume mixer with saturating accumulation: top level.
// Channels: smp_ch (sink) takes one sample word per active source and frame;
// mix_ch (source) gives one mixed left/right word per frame; cfg (sink) writes
// the eight per-channel volume divisors (index 2k left, 2k+1 right of channel k),
// always ready, and is only to be written while the mixer is idle.
// Each side is scaled by (sample << frac bits) / divisor through a restoring
// divider, one quotient bit per cycle, with left and right in parallel lanes.
// Sequence: an accepted word passes through the divide steps and the left and
// right accumulate steps, and the next word is taken only once the mixer is
// back in idle. A word that closes the frame adds an emit step that loads the
// output register and raises mix_ch.valid.
// Reset: all divisors return to 256, both accumulators to zero, output empty.
// Stall: a result waits in the output register while the next word is taken and
// worked; if that word also closes a frame, the emit holds until mix_ch drains.
// Depends on svsm_pkg, the channel interfaces, svsm_ctrl and svsm_dp.
`timescale 1ns / 1ps

module stereo_volume_saturating_mixer (
    input  logic        clk,
    input  logic        rst_n,
    svsm_smp_if.sink    smp_ch,
    svsm_mix_if.source  mix_ch,
    svsm_cfg_if.sink    cfg
);
    svsm_pkg::ctrl_cmd_t cmd;
    svsm_pkg::dp_sts_t   sts;
    logic                in_ready;

    // Sequence one word at a time
    svsm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (smp_ch.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Divide, accumulate, hold the result
    svsm_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .channel        (smp_ch.channel),
        .sample_in      (smp_ch.sample_in),
        .first_of_frame (smp_ch.first_of_frame),
        .last_of_frame  (smp_ch.last_of_frame),
        .mono_out       (smp_ch.mono_out),
        .cfg_valid      (cfg.valid),
        .cfg_index      (cfg.index),
        .cfg_data       (cfg.data),
        .out_ready      (mix_ch.ready),
        .out_valid      (mix_ch.valid),
        .mix_left       (mix_ch.mix_left),
        .mix_right      (mix_ch.mix_right)
    );

    assign smp_ch.ready = in_ready;
    // Divisor writes are registered directly, so never back-pressure the config port
    assign cfg.ready    = 1'b1;
endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the stereo volume saturating mixer: directed
// frames, divisor extremes, a long output stall and random frames.
// Depends on svsm_pkg, the three channel interfaces and the mixer RTL.

module tb_top;
    import svsm_pkg::*;

    // Longest stretch without any handshake before the run is declared hung.
    // The long output hold below is the worst legal case.
    localparam int WATCHDOG_LIMIT = 5000;
    // A word that closes no frame may still be in the divider this long
    localparam int DRAIN_CYCLES   = 40;
    localparam int LONG_HOLD      = 600;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_WORDS    = 100;
    localparam int STALL_WORDS    = 20;
    localparam int MAX_GAP        = 12;

    localparam logic [DIV_W-1:0]     DIV_ZERO    = '0;
    localparam logic [DIV_W-1:0]     DIV_MAX     = '1;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_IDX = '1;

    typedef struct {
        logic [CH_W-1:0]             channel;
        logic signed [SAMPLE_W-1:0]  sample;
        logic                        first;
        logic                        last;
        logic                        mono;
    } smp_word_t;

    typedef struct {
        logic signed [SAMPLE_W-1:0]  left;
        logic signed [SAMPLE_W-1:0]  right;
    } mix_pair_t;

    logic clk;
    logic rst_n;

    svsm_smp_if smp_ch();
    svsm_mix_if mix_ch();
    svsm_cfg_if cfg_ch();

    stereo_volume_saturating_mixer u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .smp_ch (smp_ch),
        .mix_ch (mix_ch),
        .cfg    (cfg_ch)
    );

    // Mirror of the mixer: divisor bank and the two accumulators
    logic [DIV_W-1:0]           divisor_tab [NUM_REGS];
    logic signed [SAMPLE_W-1:0] acc_l;
    logic signed [SAMPLE_W-1:0] acc_r;

    // Mixed words owed by the mixer, oldest first
    mix_pair_t expected_mix_q [$];

    int  n_errors;
    int  n_words;
    int  n_mixes;
    int  n_cfg_writes;
    int  idle_cycles;

    // Idling controls: eager sides never pause; hold_request asks the output
    // side for one long stall
    bit  send_eager;
    bit  take_eager;
    bit  hold_request;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Scale one side: (sample << frac) / divisor, truncating toward zero.
    // Zero samples and divisors of zero or one pass unscaled.
    function automatic longint scaled_side(input logic signed [SAMPLE_W-1:0] smp,
                                           input logic [DIV_W-1:0] dvs);
        longint num;
        num = longint'(smp) * (longint'(1) << VOLUME_FRAC_BITS);
        if (smp == '0 || dvs <= DIV_ONE)
            return longint'(smp);
        return num / longint'(dvs);
    endfunction

    // Add with clamping to the 16-bit signed range
    function automatic logic signed [SAMPLE_W-1:0] sat16(
        input logic signed [SAMPLE_W-1:0] acc,
        input longint                     v
    );
        longint s;
        s = longint'(acc) + v;
        if (s > longint'(SAMPLE_MAX))
            return SAMPLE_MAX;
        if (s < longint'(SAMPLE_MIN))
            return SAMPLE_MIN;
        return s[SAMPLE_W-1:0];
    endfunction

    // Advance the mirror by one accepted word; returns 1 with the mixed pair
    // when the word closes a frame
    function automatic bit mix_predict(input smp_word_t w, output mix_pair_t p);
        longint l;
        longint r;
        if (w.first)
        begin
            acc_l = '0;
            acc_r = '0;
        end
        if (int'(w.channel) < CHANNELS)
        begin
            l = scaled_side(w.sample, divisor_tab[{w.channel, SIDE_LEFT}]);
            r = scaled_side(w.sample, divisor_tab[{w.channel, SIDE_RIGHT}]);
            if (w.mono)
            begin
                // Left side first, then right, both into the left accumulator
                acc_l = sat16(acc_l, l);
                acc_l = sat16(acc_l, r);
            end
            else
            begin
                acc_l = sat16(acc_l, l);
                acc_r = sat16(acc_r, r);
            end
        end
        p.left  = acc_l;
        p.right = acc_r;
        return w.last;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic smp_word_t sample_word(input int ch, input int smp,
                                              input bit f, input bit l, input bit m);
        smp_word_t w;
        w.channel = CH_W'(ch);
        w.sample  = SAMPLE_W'(smp);
        w.first   = f;
        w.last    = l;
        w.mono    = m;
        return w;
    endfunction

    function automatic logic [CFG_IDX_W-1:0] div_index(input int ch, input logic side);
        logic [CH_W-1:0] c;
        c = CH_W'(ch);
        return CFG_IDX_W'({c, side});
    endfunction

    // A mix of moderate samples, so that frames mix rather than saturate,
    // fully random ones, the extremes and zero
    function automatic logic signed [SAMPLE_W-1:0] draw_sample();
        logic signed [SAMPLE_W-1:0] v;
        v = SAMPLE_W'($urandom_range(0, 4000));
        case ($urandom_range(0, 7))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return '0;
            3, 4:    return v - 16'sd2000;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic [DIV_W-1:0] draw_divisor();
        case ($urandom_range(0, 9))
            0:       return DIV_ZERO;
            1:       return DIV_ONE;
            2:       return DIV_W'(2);
            3:       return DIV_MAX;
            4:       return DIV_W'($urandom_range(3, 64));
            8:       return DIV_W'($urandom);
            9:       return DIV_W'($urandom_range(2048, 65536));
            default: return DIV_W'($urandom_range(128, 2048));
        endcase
    endfunction

    // Offer one sample word after a random gap, or none when send_eager is set;
    // hold it until taken, then update the mirror. valid stays high when the next word follows at once.
    task automatic send_word(input smp_word_t w);
        int        gap;
        mix_pair_t p;
        gap = send_eager ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            @(negedge clk);
            smp_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        smp_ch.valid          <= 1'b1;
        smp_ch.channel        <= w.channel;
        smp_ch.sample_in      <= w.sample;
        smp_ch.first_of_frame <= w.first;
        smp_ch.last_of_frame  <= w.last;
        smp_ch.mono_out       <= w.mono;
        do @(posedge clk); while (!smp_ch.ready);
        n_words++;
        if (mix_predict(w, p))
            expected_mix_q.push_back(p);
    endtask

    // Drop valid, wait for every owed word, then let the divider drain
    task automatic wait_mixer_idle();
        @(negedge clk);
        smp_ch.valid <= 1'b0;
        while (expected_mix_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write one divisor register; indexes past the bank are ignored
    task automatic write_divisor(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [DIV_W-1:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        n_cfg_writes++;
        if (idx < REG_LIMIT)
            divisor_tab[idx[REG_SEL_W:0]] = value;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // One frame of one to four words; one in five has random marks instead
    task automatic send_random_frame();
        smp_word_t w;
        int        len;
        bit        mono_frame;
        bit        broken;
        broken     = ($urandom_range(0, 4) == 0);
        mono_frame = ($urandom_range(0, 3) == 0);
        len        = $urandom_range(1, 4);
        for (int i = 0; i < len; i++)
        begin
            w.channel = CH_W'($urandom);
            w.sample  = draw_sample();
            if (broken)
            begin
                w.first = 1'($urandom);
                w.last  = 1'($urandom);
                w.mono  = 1'($urandom);
            end
            else
            begin
                w.first = (i == 0);
                w.last  = (i == len - 1);
                w.mono  = mono_frame ^ ($urandom_range(0, 7) == 0);
            end
            send_word(w);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset divisors of 256 give unity gain, so the mix is plain saturating sums
    task automatic test_directed_mixing();
        // Extremes of the sample, stereo, one word per frame
        send_word(sample_word(0, SAMPLE_MAX, 1, 1, 0));
        send_word(sample_word(1, SAMPLE_MIN, 1, 1, 0));
        // Zero sample adds nothing
        send_word(sample_word(2, 0, 1, 1, 0));
        // Positive overflow clamps, then a small negative pulls back
        send_word(sample_word(0, 20000, 1, 0, 0));
        send_word(sample_word(1, 20000, 0, 0, 0));
        send_word(sample_word(2, -5, 0, 1, 0));
        // Mono frame: right stays at zero
        send_word(sample_word(3, 1000, 1, 0, 1));
        send_word(sample_word(0, -3000, 0, 1, 1));
        // No first mark: accumulators carry over from the frame before
        send_word(sample_word(1, 7, 0, 1, 0));
        // Stereo and mono words within one frame
        send_word(sample_word(2, 100, 1, 0, 0));
        send_word(sample_word(3, 50, 0, 1, 1));
        // Word with neither mark, then a closing word
        send_word(sample_word(0, -1, 0, 0, 0));
        send_word(sample_word(1, 1, 0, 1, 0));
        // Negative overflow clamps
        send_word(sample_word(0, SAMPLE_MIN, 1, 0, 0));
        send_word(sample_word(1, SAMPLE_MIN, 0, 1, 0));
    endtask

    task automatic test_divisor_extremes();
        wait_mixer_idle();
        write_divisor(div_index(0, SIDE_LEFT),  DIV_ZERO);
        write_divisor(div_index(0, SIDE_RIGHT), DIV_ONE);
        write_divisor(div_index(1, SIDE_LEFT),  DIV_W'(2));
        write_divisor(div_index(1, SIDE_RIGHT), DIV_MAX);
        write_divisor(div_index(2, SIDE_LEFT),  DIV_W'(3));
        write_divisor(div_index(2, SIDE_RIGHT), DIV_W'(65535));
        write_divisor(div_index(3, SIDE_LEFT),  DIV_W'(1024));
        write_divisor(div_index(3, SIDE_RIGHT), DIV_W'(100000));
        // Writes past the bank must leave it untouched
        write_divisor(REG_LIMIT,   DIV_W'(5));
        write_divisor(REG_TOP_IDX, DIV_W'(7));
        // Divisor zero and one pass the sample unscaled
        send_word(sample_word(0, 12345, 1, 1, 0));
        send_word(sample_word(0, -1, 1, 1, 0));
        // Divisor two overflows the side; the largest divisor scales to zero
        send_word(sample_word(1, 1, 1, 1, 0));
        send_word(sample_word(1, SAMPLE_MIN, 1, 1, 0));
        // Truncation toward zero of a negative quotient
        send_word(sample_word(2, -7, 1, 1, 0));
        send_word(sample_word(3, SAMPLE_MAX, 1, 1, 1));
        send_word(sample_word(3, -32767, 1, 1, 0));
    endtask

    // Hold the output off for a long stretch while words keep coming, so that
    // the output register fills and the input stalls
    task automatic test_output_backpressure();
        send_eager   = 1'b1;
        hold_request = 1'b1;
        for (int i = 0; i < STALL_WORDS; i++)
            send_word(sample_word($urandom_range(0, CHANNELS - 1), draw_sample(),
                                  1, 1, 1'($urandom)));
        send_eager = 1'b0;
    endtask

    task automatic test_random_frames();
        int phase_start;
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            wait_mixer_idle();
            for (int r = 0; r < NUM_REGS; r++)
            begin
                case (ph)
                    0:       write_divisor(CFG_IDX_W'(r), DIV_ONE);
                    1:       write_divisor(CFG_IDX_W'(r), DIV_MAX);
                    2:       write_divisor(CFG_IDX_W'(r), DIV_RESET);
                    default: write_divisor(CFG_IDX_W'(r), draw_divisor());
                endcase
            end
            write_divisor(CFG_IDX_W'($urandom_range(NUM_REGS, (1 << CFG_IDX_W) - 1)),
                          DIV_W'($urandom));
            // Every third phase runs back to back on both sides
            send_eager  = (ph % 3 == 1);
            take_eager  = (ph % 3 == 1);
            phase_start = n_words;
            while (n_words - phase_start < PHASE_WORDS)
                send_random_frame();
        end
        send_eager = 1'b0;
        take_eager = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Output side, checker and watchdog
    // ------------------------------------------------------------------

    // Draw a stall before each mixed word; honour one long hold on request
    initial
    begin : mix_taker
        int stall;
        @(posedge rst_n);
        forever
        begin
            if (hold_request)
            begin
                stall        = LONG_HOLD;
                hold_request = 1'b0;
            end
            else
                stall = take_eager ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0)
            begin
                @(negedge clk);
                mix_ch.ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            mix_ch.ready <= 1'b1;
            do @(posedge clk); while (!mix_ch.valid);
        end
    end

    // Compare each mixed word with the oldest owed one
    always @(posedge clk)
    begin : mix_checker
        mix_pair_t want;
        if (rst_n && mix_ch.valid && mix_ch.ready)
        begin
            n_mixes++;
            if (expected_mix_q.size() == 0)
            begin
                $error("mixed word with no frame pending: mix_left %0d mix_right %0d",
                       mix_ch.mix_left, mix_ch.mix_right);
                n_errors++;
            end
            else
            begin
                want = expected_mix_q.pop_front();
                if (mix_ch.mix_left !== want.left)
                begin
                    $error("mix_left expected %0d got %0d", want.left, mix_ch.mix_left);
                    n_errors++;
                end
                if (mix_ch.mix_right !== want.right)
                begin
                    $error("mix_right expected %0d got %0d", want.right, mix_ch.mix_right);
                    n_errors++;
                end
            end
        end
    end

    // Count cycles with no handshake on any channel
    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((smp_ch.valid && smp_ch.ready) || (mix_ch.valid && mix_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles, %0d mixed words owed",
                         WATCHDOG_LIMIT, expected_mix_q.size());
                $display("FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        // Known values on every input from time zero
        smp_ch.valid          = 1'b0;
        smp_ch.channel        = '0;
        smp_ch.sample_in      = '0;
        smp_ch.first_of_frame = 1'b0;
        smp_ch.last_of_frame  = 1'b0;
        smp_ch.mono_out       = 1'b0;
        mix_ch.ready          = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.index          = '0;
        cfg_ch.data           = '0;
        n_errors     = 0;
        n_words      = 0;
        n_mixes      = 0;
        n_cfg_writes = 0;
        idle_cycles  = 0;
        send_eager   = 1'b0;
        take_eager   = 1'b0;
        hold_request = 1'b0;

        // Mirror starts from the reset state of the mixer
        for (int r = 0; r < NUM_REGS; r++)
            divisor_tab[r] = DIV_RESET;
        acc_l = '0;
        acc_r = '0;

        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_mixing();
        test_divisor_extremes();
        test_output_backpressure();
        test_random_frames();
        wait_mixer_idle();

        $display("Covered %0d sample words, %0d mixed words and %0d divisor writes:",
                 n_words, n_mixes, n_cfg_writes);
        $display("unity gain, divisor extremes, mono and carried frames, long output stall.");
        if (n_errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/svsm_pkg.sv
rtl/svsm_smp_if.sv
rtl/svsm_mix_if.sv
rtl/svsm_cfg_if.sv
rtl/svsm_div_lane.sv
rtl/svsm_ctrl.sv
rtl/svsm_dp.sv
rtl/stereo_volume_saturating_mixer.sv
tb/tb_top.sv
